// File: rtl/nearest_centroid_classifier_defines.svh
// Assertion macros shared by the nearest centroid classifier RTL.
`ifndef NEAREST_CENTROID_CLASSIFIER_DEFINES_SVH
`define NEAREST_CENTROID_CLASSIFIER_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define NCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that holds in the cycle after its condition.
`define NCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ncc_pkg.sv
// Types and constants of the nearest centroid classifier.
`default_nettype none

package ncc_pkg;

	// Default sizes of the centroid store.
	localparam int MAX_CATEGORIES_DEF = 16;
	localparam int VECTOR_LENGTH_DEF  = 256;

	// Field widths.
	localparam int CAT_IDX_W  = 4;
	localparam int ELEM_IDX_W = 8;
	localparam int VALUE_W    = 16;
	localparam int COUNT_W    = 5;
	localparam int SQ_W       = 32;
	localparam int DIST_W     = 40;
	localparam int TALLY_W    = 32;

	// Stream and register port widths.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 80;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register word index (byte address bit 2) and reset value.
	localparam logic REG_CATEGORY_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_FEATURE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_TALLY_RD,
		ST_TALLY_WR
	} state_t;

endpackage

`default_nettype wire

// File: rtl/nearest_centroid_classifier.sv
// Nearest centroid classifier with squared Euclidean distance over memory-held centroids.
//
//   Channel   Direction  Transfer meaning
//   s_axis    in         centroid load (tuser=0) or feature element (tuser=1)
//   m_axis    out        best category, its distance and its tally
//   apb       in         category_count register at byte address 0
//
// A centroid load is written to the store as it is accepted. For a feature element the
// sequencer scans the N active categories, the centroid store read port serving one
// category per cycle, then waits while the diff, square and accumulate stages drain.
// A last element then passes through the tally read and write states, and waits there
// while a previous result is not taken.
// Reset clears control state and the valid bits of accumulators and tallies; the
// centroid store is not cleared. Input is taken only when the pipeline is empty.
`default_nettype none
`include "nearest_centroid_classifier_defines.svh"

module nearest_centroid_classifier import ncc_pkg::*; #(
	parameter int MAX_CATEGORIES = MAX_CATEGORIES_DEF,
	parameter int VECTOR_LENGTH  = VECTOR_LENGTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream.
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: category_index[3:0], element_index[11:4], element_value[27:12], zero fill.
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: opcode.
	input  wire logic                  s_axis_tuser,
	// tlast: last_element.
	input  wire logic                  s_axis_tlast,
	// Result stream.
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// tdata: best_category[3:0], best_distance[43:4], category_tally[75:44], zero fill.
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// Register port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int CAT_W       = $clog2(MAX_CATEGORIES);
	localparam int STORE_DEPTH = MAX_CATEGORIES * VECTOR_LENGTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Input field unpacking.
	logic [CAT_IDX_W-1:0]  in_cat;
	logic [ELEM_IDX_W-1:0] in_elem;
	logic [VALUE_W-1:0]    in_val;
	logic                  in_xfer;
	logic                  load_we;
	logic                  feat_start;

	assign in_cat  = s_axis_tdata[CAT_IDX_W-1:0];
	assign in_elem = s_axis_tdata[CAT_IDX_W+ELEM_IDX_W-1:CAT_IDX_W];
	assign in_val  = s_axis_tdata[CAT_IDX_W+ELEM_IDX_W+VALUE_W-1:CAT_IDX_W+ELEM_IDX_W];

	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign feat_start = in_xfer && (s_axis_tuser == OP_FEATURE);
	assign load_we    = in_xfer && (s_axis_tuser == OP_LOAD)
		&& (32'(in_cat) < 32'(MAX_CATEGORIES))
		&& (32'(in_elem) < 32'(VECTOR_LENGTH));

	// Configuration register.
	logic [COUNT_W-1:0] count_q;
	logic               cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CATEGORY_COUNT);
	assign prdata = (paddr[2] == REG_CATEGORY_COUNT) ?
		{{(APB_DATA_W-COUNT_W){1'b0}}, count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Highest active category: zero acts as one, large values clamp to the store size.
	logic [CAT_W-1:0] last_cat;

	always_comb begin
		if (count_q == '0) begin
			last_cat = '0;
		end else if (32'(count_q) >= 32'(MAX_CATEGORIES)) begin
			last_cat = CAT_W'(MAX_CATEGORIES - 1);
		end else begin
			last_cat = CAT_W'(count_q - 5'd1);
		end
	end

	// Feature element held for the whole category pass.
	logic [ELEM_IDX_W-1:0] elem_q;
	logic [VALUE_W-1:0]    val_q;
	logic                  last_q;
	logic                  in_range_q;

	always_ff @(posedge clk) begin
		if (feat_start) begin
			elem_q     <= in_elem;
			val_q      <= in_val;
			last_q     <= s_axis_tlast;
			in_range_q <= (32'(in_elem) < 32'(VECTOR_LENGTH));
		end
	end

	// Sequencer.
	state_t           state_q;
	state_t           state_d;
	logic             issue;
	logic             tally_re;
	logic             tally_commit;
	logic [CAT_W-1:0] cnt_q;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		issue         = 1'b0;
		tally_re      = 1'b0;
		tally_commit  = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (feat_start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (cnt_q == last_cat) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3)) begin
					state_d = last_q ? ST_TALLY_RD : ST_IDLE;
				end
			end
			ST_TALLY_RD: begin
				tally_re = 1'b1;
				state_d  = ST_TALLY_WR;
			end
			ST_TALLY_WR: begin
				if (!out_valid_q || m_axis_tready) begin
					tally_commit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Category counter of the pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (feat_start) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Centroid store: loads write, the pass reads one category per cycle.
	logic [VALUE_W-1:0]    store_mem [STORE_DEPTH];
	logic [VALUE_W-1:0]    cent_s1;
	logic [ADDR_W-1:0]     store_waddr;
	logic [ADDR_W-1:0]     store_raddr;
	logic [ELEM_IDX_W-1:0] elem_use;

	assign elem_use    = in_range_q ? elem_q : '0;
	assign store_waddr = ADDR_W'(32'(in_cat) * 32'(VECTOR_LENGTH) + 32'(in_elem));
	assign store_raddr = ADDR_W'(32'(cnt_q) * 32'(VECTOR_LENGTH) + 32'(elem_use));

	always_ff @(posedge clk) begin
		if (load_we) begin
			store_mem[store_waddr] <= in_val;
		end
		if (issue) begin
			cent_s1 <= store_mem[store_raddr];
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Difference and square stages.
	logic [CAT_W-1:0]   cat_s1;
	logic [CAT_W-1:0]   cat_s2;
	logic [CAT_W-1:0]   cat_s3;
	logic [VALUE_W-1:0] diff_s2;
	logic [SQ_W-1:0]    sq_s3;

	always_ff @(posedge clk) begin
		cat_s1 <= cnt_q;
		cat_s2 <= cat_s1;
		cat_s3 <= cat_s2;
		if (!in_range_q) begin
			diff_s2 <= '0;
		end else if (val_q > cent_s1) begin
			diff_s2 <= val_q - cent_s1;
		end else begin
			diff_s2 <= cent_s1 - val_q;
		end
		sq_s3 <= diff_s2 * diff_s2;
	end

	// Accumulator memory: read in the square stage, written back in the add stage.
	// Successive cycles touch different categories, so no forwarding is needed.
	logic [DIST_W-1:0]         acc_mem [MAX_CATEGORIES];
	logic [DIST_W-1:0]         acc_rd_s3;
	logic                      acc_hit_s3;
	logic [MAX_CATEGORIES-1:0] acc_vld_q;
	logic [DIST_W-1:0]         acc_old;
	logic [DIST_W:0]           acc_sum;
	logic [DIST_W-1:0]         acc_sat;

	assign acc_old = acc_hit_s3 ? acc_rd_s3 : '0;
	assign acc_sum = {1'b0, acc_old} + (DIST_W+1)'(sq_s3);
	assign acc_sat = acc_sum[DIST_W] ? {DIST_W{1'b1}} : acc_sum[DIST_W-1:0];

	always_ff @(posedge clk) begin
		acc_rd_s3 <= acc_mem[cat_s2];
		if (v_s3) begin
			acc_mem[cat_s3] <= acc_sat;
		end
	end

	// An accumulator without its valid bit reads as zero; all clear after each vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q  <= '0;
			acc_hit_s3 <= 1'b0;
		end else begin
			acc_hit_s3 <= acc_vld_q[cat_s2];
			if (tally_commit) begin
				acc_vld_q <= '0;
			end else if (v_s3) begin
				acc_vld_q[cat_s3] <= 1'b1;
			end
		end
	end

	// Running minimum in ascending category order; strict less keeps the lowest index.
	logic [CAT_W-1:0]  best_cat_q;
	logic [DIST_W-1:0] best_dist_q;

	always_ff @(posedge clk) begin
		if (v_s3 && ((cat_s3 == '0) || (acc_sat < best_dist_q))) begin
			best_cat_q  <= cat_s3;
			best_dist_q <= acc_sat;
		end
	end

	// Tally memory: read for the winner, incremented with saturation, written back.
	logic [TALLY_W-1:0]        tally_mem [MAX_CATEGORIES];
	logic [TALLY_W-1:0]        tally_rd_q;
	logic                      tally_hit_q;
	logic [MAX_CATEGORIES-1:0] tally_vld_q;
	logic [TALLY_W-1:0]        tally_old;
	logic [TALLY_W-1:0]        tally_new;

	assign tally_old = tally_hit_q ? tally_rd_q : '0;
	assign tally_new = (tally_old == {TALLY_W{1'b1}}) ? tally_old : tally_old + 1'b1;

	always_ff @(posedge clk) begin
		if (tally_re) begin
			tally_rd_q <= tally_mem[best_cat_q];
		end
		if (tally_commit) begin
			tally_mem[best_cat_q] <= tally_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_vld_q <= '0;
			tally_hit_q <= 1'b0;
		end else begin
			if (tally_re) begin
				tally_hit_q <= tally_vld_q[best_cat_q];
			end
			if (tally_commit) begin
				tally_vld_q[best_cat_q] <= 1'b1;
			end
		end
	end

	// Output register.
	logic [CAT_IDX_W-1:0] out_cat_q;
	logic [DIST_W-1:0]    out_dist_q;
	logic [TALLY_W-1:0]   out_tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tally_commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tally_commit) begin
			out_cat_q   <= CAT_IDX_W'(best_cat_q);
			out_dist_q  <= best_dist_q;
			out_tally_q <= tally_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-CAT_IDX_W-DIST_W-TALLY_W){1'b0}},
		out_tally_q, out_dist_q, out_cat_q};

	// Checks.
	`NCC_ASSERT_SAME(a_ready_empty, s_axis_tready, !(v_s1 || v_s2 || v_s3), "input taken while pass in flight")
	`NCC_ASSERT_SAME(a_cnt_bound, state_q == ST_SCAN, cnt_q <= last_cat, "category counter past last active category")
	`NCC_ASSERT_NEXT(a_out_source, !m_axis_tvalid && (state_q != ST_TALLY_WR), !m_axis_tvalid, "result appeared without tally commit")

endmodule

`default_nettype wire
